@@ rtl/tw_pkg.sv @@
package tw_pkg;

    localparam int DEF_NUM_HANDLES = 64;
    localparam int DEF_WHEEL_SLOTS = 60;

    localparam int MOD_BITS  = 8;
    localparam int MOD_STEPS = 32 / MOD_BITS;

    localparam logic [2:0] ACT_CREATE     = 3'd0;
    localparam logic [2:0] ACT_RESCHEDULE = 3'd1;
    localparam logic [2:0] ACT_CANCEL     = 3'd2;
    localparam logic [2:0] ACT_FREE       = 3'd3;
    localparam logic [2:0] ACT_LOOKUP     = 3'd4;
    localparam logic [2:0] ACT_TICK       = 3'd5;

    localparam logic [2:0] KIND_DONE      = 3'd0;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd1;
    localparam logic [2:0] KIND_FIRED     = 3'd2;
    localparam logic [2:0] KIND_NONE_DUE  = 3'd3;
    localparam logic [2:0] KIND_LOOKUP    = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  handle;
        logic [31:0] user_tag;
        logic [31:0] delay_seconds;
        logic [31:0] now_seconds;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  out_handle;
        logic [31:0] out_tag;
        logic [31:0] out_expire;
        logic        is_scheduled;
        logic        last;
    } t_rsp;

endpackage

@@ rtl/tw_ram.sv @@
module tw_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

@@ rtl/tw_mod.sv @@
module tw_mod
    import tw_pkg::*;
#(
    parameter int WHEEL_SLOTS = DEF_WHEEL_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [31:0]                    i_value,
    output logic                           o_done,
    output logic [$clog2(WHEEL_SLOTS)-1:0] o_rem
);

    localparam int RW = $clog2(WHEEL_SLOTS);
    localparam int CW = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
    localparam logic [RW:0] SL = (RW + 1)'(WHEEL_SLOTS);

    logic [31:0]   r_val;
    logic [RW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic [RW-1:0] n_rem;

    always_comb begin
        logic [31:0] v;
        logic [RW:0] t;
        v     = r_val;
        n_rem = r_rem;
        for (int i = 0; i < MOD_BITS; i++) begin
            t = {n_rem, v[31]};
            if (t >= SL) begin
                t = t - SL;
            end
            n_rem = t[RW-1:0];
            v     = v << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_val <= i_value;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_run) begin
            r_val <= r_val << MOD_BITS;
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(MOD_STEPS - 1)) begin
                r_run <= 1'b0;
            end
        end
    end

    assign o_done = !r_run;
    assign o_rem  = r_rem;

endmodule

@@ rtl/timing_wheel_timeout_table.sv @@
// Channel   Direction  Handshake                    Beat
// cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_data, start second
// in        in         i_in_valid / o_in_ready      i_in, one request
// out       out        o_out_valid / i_out_ready    o_out, one result
//
// The slot index for an append or a tick comes from a shared remainder unit, and
// unlink and append each read the link memories before they write them. A tick
// reads the slot head, then reads and evaluates each entry of the walked slot in
// turn. Reset is synchronous and needs no clearing pass. A stalled output holds
// the walk at the next firing entry; requests are taken one at a time.
module timing_wheel_timeout_table
    import tw_pkg::*;
#(
    parameter int NUM_HANDLES = DEF_NUM_HANDLES,
    parameter int WHEEL_SLOTS = DEF_WHEEL_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out
);

    localparam int HW = $clog2(NUM_HANDLES);
    localparam int LW = HW + 1;
    localparam int RW = $clog2(WHEEL_SLOTS);
    localparam logic [LW-1:0] NIL = {1'b1, {HW{1'b0}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_UL    = 4'd2;
    localparam logic [3:0] S_AWAIT = 4'd3;
    localparam logic [3:0] S_A1    = 4'd4;
    localparam logic [3:0] S_A2    = 4'd5;
    localparam logic [3:0] S_LKD   = 4'd6;
    localparam logic [3:0] S_RES   = 4'd7;
    localparam logic [3:0] S_TWAIT = 4'd8;
    localparam logic [3:0] S_TH    = 4'd9;
    localparam logic [3:0] S_TRD   = 4'd10;
    localparam logic [3:0] S_TEV   = 4'd11;
    localparam logic [3:0] S_TEND  = 4'd12;

    logic [3:0]             r_state;
    t_req                   r_req;
    logic [31:0]            r_start;
    logic [HW-1:0]          r_cur;
    logic [LW-1:0]          r_t;
    logic [NUM_HANDLES-1:0] r_valid;
    logic [NUM_HANDLES-1:0] r_sched;
    logic [WHEEL_SLOTS-1:0] r_slot_ok;
    t_rsp                   r_res;
    t_rsp                   r_pend;
    logic                   r_pv;
    t_rsp                   r_out;
    logic                   r_ov;

    logic          exp_we, tag_we, nxt_we, prv_we, esl_we, hd_we, tl_we;
    logic [HW-1:0] exp_wa, tag_wa, nxt_wa, prv_wa, esl_wa;
    logic [RW-1:0] hd_wa, tl_wa;
    logic [31:0]   exp_wd, tag_wd, exp_q, tag_q;
    logic [LW-1:0] nxt_wd, prv_wd, hd_wd, tl_wd, nxt_q, prv_q, hd_q, tl_q;
    logic [RW-1:0] esl_wd, esl_q;
    logic          ent_re, esl_re, hd_re, tl_re;
    logic [HW-1:0] ent_ra;
    logic [RW-1:0] slot_ra;

    logic          mod_start, mod_done;
    logic [31:0]   mod_val;
    logic [RW-1:0] rem;

    logic [2:0]    act;
    logic [HW-1:0] h;
    logic          in_rng, live, bad, need_ul, is_app;
    logic [32:0]   sum;
    logic [31:0]   new_exp;
    logic          out_free, out_load, fire, ul_en;
    logic [RW-1:0] ul_slot;
    logic [LW-1:0] tail_link, head_link;

    assign act      = r_req.action;
    assign h        = r_req.handle[HW-1:0];
    assign in_rng   = {1'b0, r_req.handle} < 7'(NUM_HANDLES);
    assign live     = in_rng && r_valid[h];
    assign bad      = (act > ACT_TICK) || !in_rng || (act != ACT_CREATE && !live);
    assign is_app   = (act == ACT_CREATE) || (act == ACT_RESCHEDULE);
    assign need_ul  = r_valid[h] && r_sched[h];
    assign sum      = {1'b0, r_req.now_seconds} + {1'b0, r_req.delay_seconds};
    assign new_exp  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign out_free = !r_ov || i_out_ready;
    assign fire     = exp_q <= r_req.now_seconds;
    assign out_load = ((r_state == S_RES) || (r_state == S_TEND)) ? out_free :
                      ((r_state == S_TEV) && fire && r_pv && out_free);
    assign tail_link = r_slot_ok[rem] ? tl_q : NIL;
    assign head_link = r_slot_ok[rem] ? hd_q : NIL;

    assign mod_start = (r_state == S_DEC) &&
                       ((act == ACT_TICK) || (is_app && !bad));
    assign mod_val   = ((act == ACT_TICK) ? r_req.now_seconds : new_exp) - r_start;

    tw_mod #(.WHEEL_SLOTS(WHEEL_SLOTS)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (mod_val),
        .o_done  (mod_done),
        .o_rem   (rem)
    );

    always_comb begin
        exp_we = 1'b0; exp_wa = h; exp_wd = new_exp;
        tag_we = 1'b0; tag_wa = h; tag_wd = r_req.user_tag;
        nxt_we = 1'b0; nxt_wa = h; nxt_wd = NIL;
        prv_we = 1'b0; prv_wa = h; prv_wd = NIL;
        esl_we = 1'b0; esl_wa = h; esl_wd = rem;
        hd_we  = 1'b0; hd_wa  = rem; hd_wd = NIL;
        tl_we  = 1'b0; tl_wa  = rem; tl_wd = NIL;
        ent_re = 1'b0; ent_ra = h;
        esl_re = 1'b0;
        hd_re  = 1'b0; tl_re  = 1'b0; slot_ra = rem;
        ul_en  = 1'b0; ul_slot = rem;
        case (r_state)
            S_DEC: begin
                if (act != ACT_TICK && !bad) begin
                    if (is_app) begin
                        exp_we = 1'b1;
                        tag_we = (act == ACT_CREATE);
                    end
                    if (act == ACT_LOOKUP) begin
                        ent_re = 1'b1;
                    end else if (need_ul) begin
                        ent_re = 1'b1;
                        esl_re = 1'b1;
                    end
                end
            end
            S_UL: begin
                ul_en   = 1'b1;
                ul_slot = esl_q;
            end
            S_AWAIT: begin
                tl_re = mod_done;
            end
            S_A1: begin
                prv_we = 1'b1; prv_wd = tail_link;
                nxt_we = 1'b1;
                esl_we = 1'b1;
                tl_we  = 1'b1; tl_wd = {1'b0, h};
                if (tail_link[HW]) begin
                    hd_we = 1'b1; hd_wd = {1'b0, h};
                end
            end
            S_A2: begin
                nxt_we = 1'b1; nxt_wa = r_t[HW-1:0]; nxt_wd = {1'b0, h};
            end
            S_TWAIT: begin
                hd_re = mod_done;
            end
            S_TRD: begin
                ent_re = 1'b1; ent_ra = r_cur;
            end
            S_TEV: begin
                ul_en = fire && (!r_pv || out_free);
            end
            default: begin
            end
        endcase
        if (ul_en) begin
            if (!prv_q[HW]) begin
                nxt_we = 1'b1; nxt_wa = prv_q[HW-1:0]; nxt_wd = nxt_q;
            end else begin
                hd_we = 1'b1; hd_wa = ul_slot; hd_wd = nxt_q;
            end
            if (!nxt_q[HW]) begin
                prv_we = 1'b1; prv_wa = nxt_q[HW-1:0]; prv_wd = prv_q;
            end else begin
                tl_we = 1'b1; tl_wa = ul_slot; tl_wd = prv_q;
            end
        end
    end

    tw_ram #(.W(32), .D(NUM_HANDLES)) u_exp (
        .i_clk(i_clk), .i_we(exp_we), .i_waddr(exp_wa), .i_wdata(exp_wd),
        .i_re(ent_re), .i_raddr(ent_ra), .o_rdata(exp_q)
    );
    tw_ram #(.W(32), .D(NUM_HANDLES)) u_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_wa), .i_wdata(tag_wd),
        .i_re(ent_re), .i_raddr(ent_ra), .o_rdata(tag_q)
    );
    tw_ram #(.W(LW), .D(NUM_HANDLES)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_re(ent_re), .i_raddr(ent_ra), .o_rdata(nxt_q)
    );
    tw_ram #(.W(LW), .D(NUM_HANDLES)) u_prv (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_wa), .i_wdata(prv_wd),
        .i_re(ent_re), .i_raddr(ent_ra), .o_rdata(prv_q)
    );
    tw_ram #(.W(RW), .D(NUM_HANDLES)) u_esl (
        .i_clk(i_clk), .i_we(esl_we), .i_waddr(esl_wa), .i_wdata(esl_wd),
        .i_re(esl_re), .i_raddr(h), .o_rdata(esl_q)
    );
    tw_ram #(.W(LW), .D(WHEEL_SLOTS)) u_hd (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd),
        .i_re(hd_re), .i_raddr(slot_ra), .o_rdata(hd_q)
    );
    tw_ram #(.W(LW), .D(WHEEL_SLOTS)) u_tl (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(tl_wa), .i_wdata(tl_wd),
        .i_re(tl_re), .i_raddr(slot_ra), .o_rdata(tl_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start   <= '0;
            r_valid   <= '0;
            r_sched   <= '0;
            r_slot_ok <= '0;
            r_pv      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_start <= i_cfg_data;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_res <= '{kind: bad ? KIND_NOT_FOUND : KIND_DONE,
                               out_handle: r_req.handle, out_tag: '0,
                               out_expire: (is_app && !bad) ? new_exp : 32'd0,
                               is_scheduled: 1'b0, last: 1'b1};
                    r_pv  <= 1'b0;
                    if (act == ACT_TICK) begin
                        r_state <= S_TWAIT;
                    end else if (bad) begin
                        r_state <= S_RES;
                    end else if (act == ACT_LOOKUP) begin
                        r_state <= S_LKD;
                    end else begin
                        if (act == ACT_CREATE) begin
                            r_valid[h] <= 1'b1;
                        end
                        if (act == ACT_FREE) begin
                            r_valid[h] <= 1'b0;
                        end
                        if (need_ul) begin
                            r_state <= S_UL;
                        end else if (is_app) begin
                            r_state <= S_AWAIT;
                        end else begin
                            r_state <= S_RES;
                        end
                    end
                end
                S_UL: begin
                    r_sched[h] <= 1'b0;
                    r_state    <= is_app ? S_AWAIT : S_RES;
                end
                S_AWAIT: begin
                    if (mod_done) begin
                        r_state <= S_A1;
                    end
                end
                S_A1: begin
                    r_sched[h]     <= 1'b1;
                    r_slot_ok[rem] <= 1'b1;
                    r_t            <= tail_link;
                    r_state        <= tail_link[HW] ? S_RES : S_A2;
                end
                S_A2: begin
                    r_state <= S_RES;
                end
                S_LKD: begin
                    r_res.kind         <= KIND_LOOKUP;
                    r_res.out_tag      <= tag_q;
                    r_res.out_expire   <= exp_q;
                    r_res.is_scheduled <= r_sched[h];
                    r_state            <= S_RES;
                end
                S_RES: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                S_TWAIT: begin
                    if (mod_done) begin
                        r_state <= S_TH;
                    end
                end
                S_TH: begin
                    r_cur   <= head_link[HW-1:0];
                    r_state <= head_link[HW] ? S_TEND : S_TRD;
                end
                S_TRD: begin
                    r_state <= S_TEV;
                end
                S_TEV: begin
                    if (!fire || !r_pv || out_free) begin
                        if (fire) begin
                            if (r_pv) begin
                                r_out <= r_pend;
                            end
                            r_pend <= '{kind: KIND_FIRED, out_handle: 6'(r_cur),
                                        out_tag: tag_q, out_expire: exp_q,
                                        is_scheduled: 1'b0, last: 1'b0};
                            r_pv           <= 1'b1;
                            r_valid[r_cur] <= 1'b0;
                            r_sched[r_cur] <= 1'b0;
                        end
                        r_cur   <= nxt_q[HW-1:0];
                        r_state <= nxt_q[HW] ? S_TEND : S_TRD;
                    end
                end
                S_TEND: begin
                    if (out_free) begin
                        if (r_pv) begin
                            r_out <= {r_pend[$bits(t_rsp)-1:1], 1'b1};
                        end else begin
                            r_out <= '{kind: KIND_NONE_DUE, out_handle: '0, out_tag: '0,
                                       out_expire: '0, is_scheduled: 1'b0, last: 1'b1};
                        end
                        r_pv    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule

@@ verif/timing_wheel_timeout_table_test.sv @@
`timescale 1ns / 1ps

module timing_wheel_timeout_table_test;
    import tw_pkg::*;

    localparam int HANDLES = 64;
    localparam int SLOTS = 60;
    localparam logic [6:0] NIL = 7'd127;
    localparam logic [2:0] ACT_BAD6 = 3'd6;
    localparam logic [2:0] ACT_BAD7 = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [31:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    t_req i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_rsp o_out;

    timing_wheel_timeout_table dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out(o_out)
    );

    logic [31:0] wheel_start;
    logic live_q [HANDLES];
    logic sched_q [HANDLES];
    logic [31:0] expire_q [HANDLES];
    logic [31:0] tag_q [HANDLES];
    logic [6:0] next_q [HANDLES];
    logic [6:0] prev_q [HANDLES];
    logic [6:0] head_q [SLOTS];
    logic [6:0] tail_q [SLOTS];

    t_rsp pending_rsp[$];
    t_rsp typed_rsp[$];
    logic typed_set[$];
    int errors = 0;
    logic quiet = 0;
    logic [31:0] clock_now = 0;

    typedef struct {
        t_req req;
        logic has_rsp;
        t_rsp rsp;
    } t_row;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int slot_index(logic [31:0] t);
        logic [31:0] d;
        d = t - wheel_start;
        return int'(d % 32'(SLOTS));
    endfunction

    function automatic void unlink_handle(int h);
        logic [6:0] p;
        logic [6:0] n;
        p = prev_q[h];
        n = next_q[h];
        if (p < HANDLES) next_q[p] = n;
        else for (int s = 0; s < SLOTS; s++) if (head_q[s] == h) head_q[s] = n;
        if (n < HANDLES) prev_q[n] = p;
        else for (int s = 0; s < SLOTS; s++) if (tail_q[s] == h) tail_q[s] = p;
        next_q[h] = NIL;
        prev_q[h] = NIL;
        sched_q[h] = 0;
    endfunction

    function automatic void append_handle(int h);
        int s;
        logic [6:0] t;
        s = slot_index(expire_q[h]);
        t = tail_q[s];
        prev_q[h] = t;
        next_q[h] = NIL;
        if (t < HANDLES) next_q[t] = 7'(h);
        else head_q[s] = 7'(h);
        tail_q[s] = 7'(h);
        sched_q[h] = 1;
    endfunction

    function automatic t_rsp make_rsp(logic [2:0] k, logic [5:0] h, logic [31:0] tg,
                                      logic [31:0] ex, logic sc, logic lst);
        t_rsp r;
        r.kind = k;
        r.out_handle = h;
        r.out_tag = tg;
        r.out_expire = ex;
        r.is_scheduled = sc;
        r.last = lst;
        return r;
    endfunction

    function automatic void predict_wheel(t_req q);
        int h;
        int s;
        int fired;
        logic [6:0] cur;
        logic [6:0] nxt;
        logic [31:0] sum;
        h = q.handle;
        sum = q.now_seconds + q.delay_seconds;
        if (sum < q.now_seconds) sum = 32'hFFFF_FFFF;
        if (q.action == ACT_TICK) begin
            fired = 0;
            s = slot_index(q.now_seconds);
            cur = head_q[s];
            for (int g = 0; g < HANDLES && cur < HANDLES; g++) begin
                nxt = next_q[cur];
                if (expire_q[cur] <= q.now_seconds) begin
                    pending_rsp.push_back(make_rsp(KIND_FIRED, cur[5:0], tag_q[cur],
                                                   expire_q[cur], 0, 0));
                    fired++;
                    unlink_handle(cur);
                    live_q[cur] = 0;
                end
                cur = nxt;
            end
            if (fired == 0) pending_rsp.push_back(make_rsp(KIND_NONE_DUE, 0, 0, 0, 0, 1));
            else pending_rsp[$].last = 1;
            return;
        end
        if (q.action > ACT_TICK || (q.action != ACT_CREATE && !live_q[h])) begin
            pending_rsp.push_back(make_rsp(KIND_NOT_FOUND, q.handle, 0, 0, 0, 1));
            return;
        end
        case (q.action)
            ACT_CREATE: begin
                if (live_q[h] && sched_q[h]) unlink_handle(h);
                live_q[h] = 1;
                tag_q[h] = q.user_tag;
                expire_q[h] = sum;
                append_handle(h);
                pending_rsp.push_back(make_rsp(KIND_DONE, q.handle, 0, sum, 0, 1));
            end
            ACT_RESCHEDULE: begin
                if (sched_q[h]) unlink_handle(h);
                expire_q[h] = sum;
                append_handle(h);
                pending_rsp.push_back(make_rsp(KIND_DONE, q.handle, 0, sum, 0, 1));
            end
            ACT_CANCEL: begin
                if (sched_q[h]) unlink_handle(h);
                pending_rsp.push_back(make_rsp(KIND_DONE, q.handle, 0, 0, 0, 1));
            end
            ACT_FREE: begin
                if (sched_q[h]) unlink_handle(h);
                live_q[h] = 0;
                pending_rsp.push_back(make_rsp(KIND_DONE, q.handle, 0, 0, 0, 1));
            end
            default: begin
                pending_rsp.push_back(make_rsp(KIND_LOOKUP, q.handle, tag_q[h],
                                               expire_q[h], sched_q[h], 1));
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected result kind %0d", o_out.kind);
                errors++;
            end else begin
                want = pending_rsp.pop_front();
                if (typed_set.size() != 0 && typed_set[0]) begin
                    if (typed_rsp[0] !== want) begin
                        $error("typed row disagrees with prediction: %p vs %p",
                               typed_rsp[0], want);
                        errors++;
                    end
                end
                if (want.last && typed_set.size() != 0) begin
                    void'(typed_set.pop_front());
                    void'(typed_rsp.pop_front());
                end
                if (o_out.kind !== want.kind) begin
                    $error("kind expected %0d actual %0d", want.kind, o_out.kind);
                    errors++;
                end
                if (o_out.out_handle !== want.out_handle) begin
                    $error("out_handle expected %0d actual %0d", want.out_handle,
                           o_out.out_handle);
                    errors++;
                end
                if (o_out.out_tag !== want.out_tag) begin
                    $error("out_tag expected %h actual %h", want.out_tag, o_out.out_tag);
                    errors++;
                end
                if (o_out.out_expire !== want.out_expire) begin
                    $error("out_expire expected %h actual %h", want.out_expire,
                           o_out.out_expire);
                    errors++;
                end
                if (o_out.is_scheduled !== want.is_scheduled) begin
                    $error("is_scheduled expected %0d actual %0d", want.is_scheduled,
                           o_out.is_scheduled);
                    errors++;
                end
                if (o_out.last !== want.last) begin
                    $error("last expected %0d actual %0d", want.last, o_out.last);
                    errors++;
                end
            end
        end
    end

    int sink_hold = 0;
    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_out_ready <= 1;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_out_ready <= (sink_hold == 1);
        end else if ($urandom_range(0, 9) == 0) begin
            sink_hold <= $urandom_range(1, 9);
            i_out_ready <= 0;
        end else begin
            i_out_ready <= 1;
        end
    end

    task automatic send_request(t_req q, logic typed, t_rsp r);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in <= q;
        i_in_valid <= 1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_wheel(q);
        typed_set.push_back(typed);
        typed_rsp.push_back(r);
    endtask

    task automatic drain_results();
        i_in_valid <= 0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_start(logic [31:0] v);
        i_cfg_data <= v;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        wheel_start = v;
        i_cfg_valid <= 0;
    endtask

    function automatic t_req pick_request();
        t_req q;
        int r;
        r = $urandom_range(0, 99);
        q.handle = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 11));
        q.user_tag = $urandom;
        q.delay_seconds = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 130);
        if (r < 30) q.action = ACT_CREATE;
        else if (r < 40) q.action = ACT_RESCHEDULE;
        else if (r < 47) q.action = ACT_CANCEL;
        else if (r < 54) q.action = ACT_FREE;
        else if (r < 64) q.action = ACT_LOOKUP;
        else if (r < 97) q.action = ACT_TICK;
        else q.action = $urandom_range(0, 1) ? ACT_BAD6 : ACT_BAD7;
        if ($urandom_range(0, 2) == 0) clock_now = clock_now + $urandom_range(0, 5);
        if ($urandom_range(0, 200) == 0 && clock_now < 32'hFFFF_FF00)
            clock_now = clock_now + $urandom;
        q.now_seconds = clock_now;
        return q;
    endfunction

    t_row rows[$];

    function automatic t_req req_of(logic [2:0] a, logic [5:0] h, logic [31:0] tg,
                                    logic [31:0] dl, logic [31:0] nw);
        t_req q;
        q.action = a;
        q.handle = h;
        q.user_tag = tg;
        q.delay_seconds = dl;
        q.now_seconds = nw;
        return q;
    endfunction

    function automatic void add_row(t_req q, logic has, t_rsp r);
        t_row w;
        w.req = q;
        w.has_rsp = has;
        w.rsp = r;
        rows.push_back(w);
    endfunction

    initial begin
        t_rsp none;
        t_req q;
        none = '0;
        wheel_start = 0;
        for (int i = 0; i < HANDLES; i++) begin
            live_q[i] = 0;
            sched_q[i] = 0;
            expire_q[i] = 0;
            tag_q[i] = 0;
            next_q[i] = NIL;
            prev_q[i] = NIL;
        end
        for (int s = 0; s < SLOTS; s++) begin
            head_q[s] = NIL;
            tail_q[s] = NIL;
        end
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        i_in_valid = 0;
        i_in = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        add_row(req_of(ACT_LOOKUP, 6'd0, 0, 0, 0), 1,
                make_rsp(KIND_NOT_FOUND, 6'd0, 0, 0, 0, 1));
        add_row(req_of(ACT_TICK, 6'd0, 0, 0, 0), 1, make_rsp(KIND_NONE_DUE, 0, 0, 0, 0, 1));
        add_row(req_of(ACT_CREATE, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5), 1,
                make_rsp(KIND_DONE, 6'd63, 0, 32'hFFFF_FFFF, 0, 1));
        add_row(req_of(ACT_CREATE, 6'd0, 32'h1234_5678, 32'd0, 32'd5), 1,
                make_rsp(KIND_DONE, 6'd0, 0, 32'd5, 0, 1));
        add_row(req_of(ACT_CREATE, 6'd1, 32'hA5A5_5A5A, 32'd60, 32'd5), 0, none);
        add_row(req_of(ACT_CREATE, 6'd2, 32'h0000_0001, 32'd0, 32'd5), 0, none);
        add_row(req_of(ACT_LOOKUP, 6'd0, 0, 0, 32'd5), 1,
                make_rsp(KIND_LOOKUP, 6'd0, 32'h1234_5678, 32'd5, 1, 1));
        add_row(req_of(ACT_CREATE, 6'd0, 32'h5555_AAAA, 32'd0, 32'd5), 0, none);
        add_row(req_of(ACT_CANCEL, 6'd2, 0, 0, 32'd5), 1, make_rsp(KIND_DONE, 6'd2, 0, 0, 0, 1));
        add_row(req_of(ACT_CANCEL, 6'd2, 0, 0, 32'd5), 1, make_rsp(KIND_DONE, 6'd2, 0, 0, 0, 1));
        add_row(req_of(ACT_LOOKUP, 6'd2, 0, 0, 32'd5), 0, none);
        add_row(req_of(ACT_RESCHEDULE, 6'd2, 0, 32'd1, 32'd5), 0, none);
        add_row(req_of(ACT_TICK, 6'd0, 0, 0, 32'd5), 0, none);
        add_row(req_of(ACT_TICK, 6'd0, 0, 0, 32'd6), 0, none);
        add_row(req_of(ACT_TICK, 6'd0, 0, 0, 32'd65), 0, none);
        add_row(req_of(ACT_FREE, 6'd63, 0, 0, 32'd65), 1, make_rsp(KIND_DONE, 6'd63, 0, 0, 0, 1));
        add_row(req_of(ACT_FREE, 6'd63, 0, 0, 32'd65), 1,
                make_rsp(KIND_NOT_FOUND, 6'd63, 0, 0, 0, 1));
        add_row(req_of(ACT_RESCHEDULE, 6'd40, 0, 32'd3, 32'd65), 1,
                make_rsp(KIND_NOT_FOUND, 6'd40, 0, 0, 0, 1));
        add_row(req_of(ACT_CANCEL, 6'd41, 0, 0, 32'd65), 1,
                make_rsp(KIND_NOT_FOUND, 6'd41, 0, 0, 0, 1));
        add_row(req_of(ACT_BAD6, 6'd3, 32'hFFFF_FFFF, 0, 32'd65), 1,
                make_rsp(KIND_NOT_FOUND, 6'd3, 0, 0, 0, 1));
        add_row(req_of(ACT_BAD7, 6'd63, 0, 0, 32'd65), 1,
                make_rsp(KIND_NOT_FOUND, 6'd63, 0, 0, 0, 1));
        add_row(req_of(ACT_CREATE, 6'd5, 32'h0F0F_0F0F, 32'd10, 32'd65), 0, none);

        foreach (rows[i]) send_request(rows[i].req, rows[i].has_rsp, rows[i].rsp);
        clock_now = 65;
        drain_results();

        // The wheel base moves while entries stay in their old slots.
        write_start(32'hFFFF_FFFF);
        for (int i = 0; i < 3; i++) send_request(req_of(ACT_TICK, 0, 0, 0, clock_now + i), 0, none);
        send_request(req_of(ACT_FREE, 6'd5, 0, 0, clock_now), 0, none);

        for (int n = 0; n < 440; n++) begin
            if (n == 120 || n == 240 || n == 330) begin
                drain_results();
                write_start(n == 120 ? 32'd0 : (n == 240 ? $urandom : 32'd17));
            end
            if (n == 380) quiet = 1;
            q = pick_request();
            send_request(q, 0, none);
        end
        drain_results();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
